// ===== rtl/core/plasb_pkg.sv =====
// Shared types and constants of the piecewise linear segment builder.
// No dependencies; imported by every module of the block.
`default_nettype none

package plasb_pkg;

   localparam int WORD_W = 64;
   localparam int POSITION_BITS_DEF = 32;
   localparam int SLOPE_FRAC_DEF = 40;
   localparam int ICPT_FRAC = 16;
   localparam int ICPT_W = 2 * WORD_W + 2;
   localparam logic [15:0] ERROR_BOUND_RESET = 16'd32;
   localparam logic [WORD_W-1:0] MAG_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic [WORD_W-1:0] SLOPE_MIN = {1'b1, {(WORD_W-1){1'b0}}};

   typedef struct packed {
      logic [WORD_W-1:0] key;
      logic              last_key;
   } req_payload_type;

   typedef struct packed {
      logic [WORD_W-1:0]        start_key;
      logic signed [WORD_W-1:0] slope;
      logic signed [WORD_W-1:0] intercept;
      logic                     final_segment;
      logic                     order_error;
   } rsp_payload_type;

endpackage

`default_nettype wire

// ===== rtl/core/plasb_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on plasb_pkg for the divisor width.
`default_nettype none

module plasb_div #(
   parameter int NUM_W = 73
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [NUM_W-1:0]            dividend,
   input  wire logic [plasb_pkg::WORD_W-1:0] divisor,
   output logic                             done,
   output logic [NUM_W-1:0]                 quotient,
   output logic                             rem_nonzero
);
   import plasb_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0]  work_ff, work_in;
   logic [WORD_W-1:0] rem_ff, rem_in;
   logic [WORD_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [WORD_W:0]   rem_sh;
   logic [WORD_W:0]   trial;
   logic              fits;

   always_comb begin
      rem_sh = {rem_ff, work_ff[NUM_W-1]};
      trial  = rem_sh - {1'b0, den_ff};
      fits   = !trial[WORD_W];
      work_in = work_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         work_in = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = CNT_W'(NUM_W);
         run_in  = 1'b1;
      end else if (run_ff) begin
         work_in = {work_ff[NUM_W-2:0], fits};
         rem_in  = fits ? trial[WORD_W-1:0] : rem_sh[WORD_W-1:0];
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         work_ff <= work_in;
         rem_ff  <= rem_in;
         den_ff  <= den_in;
      end
   end

   assign done        = done_ff;
   assign quotient    = work_ff;
   assign rem_nonzero = (rem_ff != '0);

endmodule

`default_nettype wire

// ===== rtl/core/plasb_mul.sv =====
// Shift-and-add multiplier, 64 by 64 bits unsigned, one partial product per cycle.
// Depends on plasb_pkg for the word width.
`default_nettype none

module plasb_mul (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [plasb_pkg::WORD_W-1:0]   mcand,
   input  wire logic [plasb_pkg::WORD_W-1:0]   mplier,
   output logic                               done,
   output logic [2*plasb_pkg::WORD_W-1:0]      product
);
   import plasb_pkg::*;

   localparam int CNT_W = $clog2(WORD_W + 1);

   logic [2*WORD_W-1:0] acc_ff, acc_in;
   logic [WORD_W-1:0]   a_ff, a_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                run_ff, run_in;
   logic                done_ff, done_in;
   logic [WORD_W:0]     sum;

   always_comb begin
      sum = {1'b0, acc_ff[2*WORD_W-1:WORD_W]} + (acc_ff[0] ? {1'b0, a_ff} : '0);
      acc_in  = acc_ff;
      a_in    = a_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in = {{WORD_W{1'b0}}, mplier};
         a_in   = mcand;
         cnt_in = CNT_W'(WORD_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         acc_in = {sum, acc_ff[WORD_W-1:1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         acc_ff  <= acc_in;
         a_ff    <= a_in;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

`default_nettype wire

// ===== rtl/core/pla_segment_builder.sv =====
// Shrinking-cone segment builder: top level with sequencer, divider and multiplier.
// A first key uses neither unit; a key that narrows the cone takes two passes of the
// shared radix-2 divider. Emitting a segment adds a multiplier pass plus any wait for
// rsp_ready, and a restart may add two more divider passes. One item at a time;
// req_ready is low meanwhile.
// Reset is synchronous: cone open, stream not started, error bound 32.
`default_nettype none

module pla_segment_builder #(
   parameter int POSITION_BITS       = plasb_pkg::POSITION_BITS_DEF,
   parameter int SLOPE_FRACTION_BITS = plasb_pkg::SLOPE_FRAC_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire plasb_pkg::req_payload_type req_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output plasb_pkg::rsp_payload_type      rsp_data,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [15:0]                csr_data
);
   import plasb_pkg::*;

   // Magnitude of (distance +/- epsilon), then the dividend with its fraction bits.
   localparam int MAG_W = ((POSITION_BITS > 16) ? POSITION_BITS : 16) + 1;
   localparam int NUM_W = MAG_W + SLOPE_FRACTION_BITS;
   localparam int QUO_W = (NUM_W > WORD_W) ? NUM_W : WORD_W;
   localparam int ICPT_SHIFT = SLOPE_FRACTION_BITS - ICPT_FRAC;

   typedef enum logic [3:0] {
      S_IDLE, S_DECIDE, S_DIV_GO, S_DIV_WAIT, S_CONE, S_TEST, S_EMIT, S_MUL_GO,
      S_MUL_WAIT, S_ICPT, S_OUT, S_RESTART, S_ADVANCE, S_LAST, S_ERR_OUT
   } state_type;

   state_type                 state_ff, state_in;
   logic [15:0]               eps_ff, eps_in;
   logic                      started_ff, started_in;
   logic [WORD_W-1:0]         k0_ff, k0_in;
   logic [POSITION_BITS-1:0]  y0_ff, y0_in;
   logic [WORD_W-1:0]         prev_ff, prev_in;
   logic [POSITION_BITS-1:0]  pos_ff, pos_in;
   logic signed [WORD_W-1:0]  low_ff, low_in;
   logic signed [WORD_W-1:0]  high_ff, high_in;
   logic                      bounded_ff, bounded_in;
   logic [WORD_W-1:0]         key_ff, key_in;
   logic                      last_ff, last_in;
   logic                      sel_hi_ff, sel_hi_in;
   logic                      restart_ff, restart_in;
   logic                      neg_ff, neg_in;
   logic signed [WORD_W-1:0]  lo_b_ff, lo_b_in;
   logic signed [WORD_W-1:0]  hi_b_ff, hi_b_in;
   logic                      final_ff, final_in;
   logic signed [WORD_W-1:0]  slope_ff, slope_in;
   logic [ICPT_W-1:0]         v_ff, v_in;
   logic signed [WORD_W-1:0]  icpt_ff, icpt_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_payload_type           rsp_data_ff, rsp_data_in;

   logic                      div_start, div_done, div_rem_nz;
   logic [NUM_W-1:0]          div_dividend, div_quo;
   logic [WORD_W-1:0]         div_divisor;
   logic                      mul_start, mul_done;
   logic [WORD_W-1:0]         mul_a;
   logic [2*WORD_W-1:0]       mul_prod;

   logic [POSITION_BITS-1:0]  pos_gap;
   logic [MAG_W-1:0]          dist_x, eps_x, hi_mag, lo_mag;
   logic [MAG_W:0]            lo_s, lo_abs;
   logic                      lo_neg;
   logic [QUO_W-1:0]          quo_x;
   logic                      q_sat, q_inexact, q_bump;
   logic [WORD_W-1:0]         q_floor, q_mag;
   logic signed [WORD_W-1:0]  bound;
   logic [WORD_W:0]           mid_sum;
   logic                      slope_neg;
   logic [ICPT_W-1:0]         y_scaled;
   logic                      v_neg;
   logic [ICPT_W-1:0]         v_abs, v_sh;
   logic                      v_sat;
   logic [WORD_W-1:0]         i_mag;
   logic                      out_free;

   plasb_div #(.NUM_W(NUM_W)) u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .dividend    (div_dividend),
      .divisor     (div_divisor),
      .done        (div_done),
      .quotient    (div_quo),
      .rem_nonzero (div_rem_nz)
   );

   plasb_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_a),
      .mplier  (k0_ff),
      .done    (mul_done),
      .product (mul_prod)
   );

   // Datapath around the shared units.
   always_comb begin
      // Position distance wraps at the position width; both cone bounds divide
      // (distance -/+ epsilon) by the key distance.
      pos_gap = pos_ff - y0_ff;
      dist_x = MAG_W'(pos_gap);
      eps_x  = MAG_W'(eps_ff);
      hi_mag = dist_x + eps_x;
      lo_s   = {1'b0, dist_x} - {1'b0, eps_x};
      lo_neg = lo_s[MAG_W];
      lo_abs = lo_neg ? (~lo_s + 1'b1) : lo_s;
      lo_mag = lo_abs[MAG_W-1:0];
      div_dividend = {(sel_hi_ff ? hi_mag : lo_mag), {SLOPE_FRACTION_BITS{1'b0}}};
      div_divisor  = key_ff - k0_ff;

      // Quotient to a bound: saturate, then round the lower bound up and the upper
      // bound down (on the magnitude this depends on the sign).
      quo_x     = QUO_W'(div_quo);
      q_sat     = (quo_x >> (WORD_W - 1)) != '0;
      q_floor   = q_sat ? MAG_MAX : {1'b0, quo_x[WORD_W-2:0]};
      q_inexact = !q_sat && div_rem_nz;
      q_bump    = q_inexact && (q_floor != MAG_MAX) && (neg_ff == sel_hi_ff);
      q_mag     = q_floor + WORD_W'(q_bump);
      bound     = neg_ff ? $signed(~q_mag + 1'b1) : $signed(q_mag);

      // Floor of the cone midpoint, one bit wider so the sum cannot overflow.
      mid_sum = {low_ff[WORD_W-1], low_ff} + {high_ff[WORD_W-1], high_ff};

      // Intercept: y0 scaled to the slope format minus slope times k0.
      slope_neg = slope_ff[WORD_W-1];
      mul_a     = slope_neg ? (~slope_ff + 1'b1) : slope_ff;
      y_scaled  = ICPT_W'(y0_ff) << SLOPE_FRACTION_BITS;
      v_neg     = v_ff[ICPT_W-1];
      v_abs     = v_neg ? (~v_ff + 1'b1) : v_ff;
      v_sh      = v_abs >> ICPT_SHIFT;
      v_sat     = (v_sh >> (WORD_W - 1)) != '0;
      i_mag     = v_sat ? MAG_MAX : {1'b0, v_sh[WORD_W-2:0]};

      out_free  = !rsp_valid_ff || rsp_ready;
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      eps_in       = eps_ff;
      started_in   = started_ff;
      k0_in        = k0_ff;
      y0_in        = y0_ff;
      prev_in      = prev_ff;
      pos_in       = pos_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      bounded_in   = bounded_ff;
      key_in       = key_ff;
      last_in      = last_ff;
      sel_hi_in    = sel_hi_ff;
      restart_in   = restart_ff;
      neg_in       = neg_ff;
      lo_b_in      = lo_b_ff;
      hi_b_in      = hi_b_ff;
      final_in     = final_ff;
      slope_in     = slope_ff;
      v_in         = v_ff;
      icpt_in      = icpt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      div_start    = 1'b0;
      mul_start    = 1'b0;

      if (csr_valid) begin
         eps_in = csr_data;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               key_in   = req_data.key;
               last_in  = req_data.last_key;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (!started_ff) begin
               // The first key of a stream opens a segment at position zero.
               k0_in      = key_ff;
               y0_in      = '0;
               prev_in    = key_ff;
               pos_in     = POSITION_BITS'(1);
               low_in     = SLOPE_MIN;
               high_in    = MAG_MAX;
               bounded_in = 1'b0;
               started_in = 1'b1;
               state_in   = S_LAST;
            end else if (key_ff < prev_ff) begin
               state_in = S_ERR_OUT;
            end else begin
               restart_in = 1'b0;
               if (key_ff != k0_ff) begin
                  sel_hi_in = 1'b0;
                  state_in  = S_DIV_GO;
               end else begin
                  state_in = S_ADVANCE;
               end
            end
         end
         S_DIV_GO: begin
            div_start = 1'b1;
            neg_in    = sel_hi_ff ? 1'b0 : lo_neg;
            state_in  = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               if (sel_hi_ff) begin
                  hi_b_in  = bound;
                  state_in = S_CONE;
               end else begin
                  lo_b_in   = bound;
                  sel_hi_in = 1'b1;
                  state_in  = S_DIV_GO;
               end
            end
         end
         S_CONE: begin
            if (lo_b_ff > low_ff) begin
               low_in = lo_b_ff;
            end
            if (hi_b_ff < high_ff) begin
               high_in = hi_b_ff;
            end
            bounded_in = 1'b1;
            state_in   = S_TEST;
         end
         S_TEST: begin
            // Right after a restart the cone is not tested; an empty cone then
            // shows up at the next key.
            if (!restart_ff && (low_ff > high_ff)) begin
               final_in = 1'b0;
               state_in = S_EMIT;
            end else begin
               state_in = S_ADVANCE;
            end
         end
         S_EMIT: begin
            slope_in = bounded_ff ? $signed(mid_sum[WORD_W:1]) : '0;
            state_in = S_MUL_GO;
         end
         S_MUL_GO: begin
            mul_start = 1'b1;
            state_in  = S_MUL_WAIT;
         end
         S_MUL_WAIT: begin
            if (mul_done) begin
               v_in = slope_neg ? (y_scaled + ICPT_W'(mul_prod))
                                : (y_scaled - ICPT_W'(mul_prod));
               state_in = S_ICPT;
            end
         end
         S_ICPT: begin
            icpt_in  = v_neg ? $signed(~i_mag + 1'b1) : $signed(i_mag);
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{start_key: k0_ff, slope: slope_ff, intercept: icpt_ff,
                                final_segment: final_ff, order_error: 1'b0};
               if (final_ff) begin
                  started_in = 1'b0;
                  pos_in     = '0;
                  low_in     = SLOPE_MIN;
                  high_in    = MAG_MAX;
                  bounded_in = 1'b0;
                  state_in   = S_IDLE;
               end else begin
                  state_in = S_RESTART;
               end
            end
         end
         S_RESTART: begin
            // The new segment starts at the previous key and position.
            k0_in      = prev_ff;
            y0_in      = pos_ff - 1'b1;
            low_in     = SLOPE_MIN;
            high_in    = MAG_MAX;
            bounded_in = 1'b0;
            restart_in = 1'b1;
            if (key_ff != prev_ff) begin
               sel_hi_in = 1'b0;
               state_in  = S_DIV_GO;
            end else begin
               state_in = S_ADVANCE;
            end
         end
         S_ADVANCE: begin
            prev_in  = key_ff;
            pos_in   = pos_ff + 1'b1;
            state_in = S_LAST;
         end
         S_LAST: begin
            if (last_ff) begin
               final_in = 1'b1;
               state_in = S_EMIT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_ERR_OUT: begin
            // A descending key is dropped and reported in one transfer.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{start_key: k0_ff, slope: '0, intercept: '0,
                                final_segment: 1'b0, order_error: 1'b1};
               state_in     = S_LAST;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         eps_ff       <= ERROR_BOUND_RESET;
         started_ff   <= 1'b0;
         k0_ff        <= '0;
         y0_ff        <= '0;
         prev_ff      <= '0;
         pos_ff       <= '0;
         low_ff       <= SLOPE_MIN;
         high_ff      <= MAG_MAX;
         bounded_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         eps_ff       <= eps_in;
         started_ff   <= started_in;
         k0_ff        <= k0_in;
         y0_ff        <= y0_in;
         prev_ff      <= prev_in;
         pos_ff       <= pos_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         bounded_ff   <= bounded_in;
         rsp_valid_ff <= rsp_valid_in;
         key_ff       <= key_in;
         last_ff      <= last_in;
         sel_hi_ff    <= sel_hi_in;
         restart_ff   <= restart_in;
         neg_ff       <= neg_in;
         lo_b_ff      <= lo_b_in;
         hi_b_ff      <= hi_b_in;
         final_ff     <= final_in;
         slope_ff     <= slope_in;
         v_ff         <= v_in;
         icpt_ff      <= icpt_in;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   // Once a key is taken the block works on it before taking another.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while an item is in progress");

   // An order error transfer carries no segment.
   a_err_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.order_error |->
         (rsp_data.slope == '0) && (rsp_data.intercept == '0) && !rsp_data.final_segment)
      else $error("order error transfer carries segment data");

   // The divider only finishes while the sequencer waits for it.
   a_div_expected: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV_WAIT))
      else $error("divider finished outside its wait state");

   // A cone never narrowed is fully open.
   a_open_cone: assert property (@(posedge clock) disable iff (reset)
      !bounded_ff |-> (low_ff == SLOPE_MIN) && (high_ff == MAG_MAX))
      else $error("unbounded cone is not open");

endmodule

`default_nettype wire
